@@ design/additive_harmonic_oscillator_unit_macros.svh @@
// Assertion macros shared by the oscillator modules.
`ifndef ADDITIVE_HARMONIC_OSCILLATOR_UNIT_MACROS_SVH
`define ADDITIVE_HARMONIC_OSCILLATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AHOS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AHOS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ahos_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the oscillator.
package ahos_pkg;

   // Sizes of the partial set and the sine table.
   localparam int NUM_PARTIALS     = 8;
   localparam int REG_FIELDS       = 8;
   localparam int SINE_ADDR_BITS   = 10;
   localparam int TABLE_DEPTH      = 1 << SINE_ADDR_BITS;
   localparam int ENTRY_BITS       = 16;
   localparam int PHASE_BITS       = 32;
   localparam int SAMPLE_BITS      = 16;
   localparam int RATIO_FIELD_BITS = 4;
   localparam int RATIO_BITS       = RATIO_FIELD_BITS + 1;
   localparam int GAIN_BITS        = 8;
   localparam int VALUE_BITS       = ENTRY_BITS + 1;
   localparam int RATIOS_BITS      = 32;
   localparam int GAINS_BITS       = 64;
   localparam int PART_BITS        = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;

   // Datapath widths that follow from the partial count.
   localparam int MAX_ENTRY  = 32767;
   localparam int MAX_GAIN   = 255;
   localparam int ACC_BITS   = $clog2(NUM_PARTIALS * MAX_GAIN * MAX_ENTRY + 1) + 1;
   localparam int MAG_BITS   = ACC_BITS - 1;
   localparam int GSUM_BITS  = $clog2(NUM_PARTIALS * MAX_GAIN + 1);
   localparam int QUOT_BITS  = 15;
   localparam int REM_BITS   = GSUM_BITS + QUOT_BITS;
   localparam int DIV_FLOOR  = 255;
   localparam int MUL_A_BITS = PHASE_BITS + 1;
   localparam int MUL_B_BITS = GAIN_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Register indexes of the write port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATIOS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAINS  = 2'd1;

   // Operations of the shared multiply-accumulate unit.
   localparam logic [1:0] MAC_NOP    = 2'd0;
   localparam logic [1:0] MAC_CLEAR  = 2'd1;
   localparam logic [1:0] MAC_PHASE  = 2'd2;
   localparam logic [1:0] MAC_WEIGHT = 2'd3;

   typedef struct packed {
      logic [1:0]                   op;
      logic [PHASE_BITS-1:0]        phase;
      logic [RATIO_BITS-1:0]        ratio;
      logic signed [VALUE_BITS-1:0] value;
      logic [GAIN_BITS-1:0]         gain;
   } mac_req_type;

   // Taylor series of sine, worked out at elaboration only.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

   typedef logic [ENTRY_BITS-1:0] sine_table_type [TABLE_DEPTH];

   function automatic logic [ENTRY_BITS-1:0] sine_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      x = ((64'(i) * 64'd2 + 64'd1) * HALF_PI_Q30) >> (SINE_ADDR_BITS + 1);
      term = x;
      sum = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'(TAYLOR_DIV[n-1]);
         if ((n & 1) != 0) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return ENTRY_BITS'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t[i] = sine_entry(i);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

@@ design/ahos_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ahos_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/ahos_mac.sv @@
// Shared multiplier: forms the partial phase and accumulates weighted sine values.
module ahos_mac (
   input  logic                                  clock,
   input  ahos_pkg::mac_req_type                 req,
   output logic [ahos_pkg::PHASE_BITS-1:0]       local_phase,
   output logic signed [ahos_pkg::ACC_BITS-1:0]  acc
);

   logic signed [ahos_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [ahos_pkg::MUL_B_BITS-1:0] mul_b;
   logic signed [ahos_pkg::PROD_BITS-1:0]  product;
   logic [ahos_pkg::PHASE_BITS-1:0]        local_ff;
   logic signed [ahos_pkg::ACC_BITS-1:0]   acc_ff;

   // Operand selection for the one multiplier.
   always_comb begin
      unique case (req.op)
         ahos_pkg::MAC_PHASE: begin
            mul_a = $signed({1'b0, req.phase});
            mul_b = $signed({{(ahos_pkg::MUL_B_BITS - ahos_pkg::RATIO_BITS){1'b0}},
                             req.ratio});
         end
         ahos_pkg::MAC_WEIGHT: begin
            mul_a = $signed({{(ahos_pkg::MUL_A_BITS - ahos_pkg::VALUE_BITS)
                              {req.value[ahos_pkg::VALUE_BITS-1]}}, req.value});
            mul_b = $signed({1'b0, req.gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // The phase product wraps modulo one turn; weighted values add into the sum.
   always_ff @(posedge clock) begin
      unique case (req.op)
         ahos_pkg::MAC_CLEAR: begin
            acc_ff <= '0;
         end
         ahos_pkg::MAC_PHASE: begin
            local_ff <= product[ahos_pkg::PHASE_BITS-1:0];
         end
         ahos_pkg::MAC_WEIGHT: begin
            acc_ff <= acc_ff + product[ahos_pkg::ACC_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   assign local_phase = local_ff;
   assign acc         = acc_ff;

endmodule

@@ design/ahos_div.sv @@
// Restoring divider, one quotient bit per cycle, signed result truncated toward zero.
`include "additive_harmonic_oscillator_unit_macros.svh"

module ahos_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   negative,
   input  logic [ahos_pkg::MAG_BITS-1:0]          magnitude,
   input  logic [ahos_pkg::GSUM_BITS-1:0]         divisor,
   output logic                                   done,
   output logic signed [ahos_pkg::SAMPLE_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(ahos_pkg::QUOT_BITS);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [CNT_BITS-1:0]                   cnt_ff, cnt_in;
   logic [ahos_pkg::REM_BITS-1:0]         rem_ff, rem_in;
   logic [ahos_pkg::REM_BITS-1:0]         dsh_ff, dsh_in;
   logic [ahos_pkg::QUOT_BITS-1:0]        quot_ff, quot_in;
   logic                                  neg_ff, neg_in;
   logic signed [ahos_pkg::SAMPLE_BITS-1:0] result_ff, result_in;
   logic                                  fits;
   logic [ahos_pkg::QUOT_BITS-1:0]        quot_next;

   // One trial subtraction of the shifted divisor per cycle.
   assign fits      = rem_ff >= dsh_ff;
   assign quot_next = {quot_ff[ahos_pkg::QUOT_BITS-2:0], fits};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quot_in   = quot_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(ahos_pkg::QUOT_BITS - 1);
         rem_in  = ahos_pkg::REM_BITS'(magnitude);
         dsh_in  = ahos_pkg::REM_BITS'(divisor) << (ahos_pkg::QUOT_BITS - 1);
         quot_in = '0;
         neg_in  = negative;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_ff - dsh_ff : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quot_in = quot_next;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? -$signed({1'b0, quot_next}) : $signed({1'b0, quot_next});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quot_ff   <= quot_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

   // A new division never starts over one in progress.
   `AHOS_ASSERT_NOW(a_no_restart, start, !busy_ff, "divider started while busy")
   // The remainder stays below twice the current shifted divisor.
   `AHOS_ASSERT_NOW(a_rem_bound, busy_ff, {1'b0, rem_ff} < {dsh_ff, 1'b0}, "quotient overflow")
   // The last step is followed by the done pulse.
   `AHOS_ASSERT_NEXT(a_done_after_last, busy_ff && !start && cnt_ff == '0, done_ff && !busy_ff, "no done pulse")

endmodule

@@ design/additive_harmonic_oscillator_unit.sv @@
// Top level of the eight-partial additive sine oscillator.
//
//   Channel  Direction  Contents
//   req_     in         tdata[31:0] phase_step
//   rsp_     out        tdata[15:0] sample (signed Q1.15)
//   csr_     in         index 0 partial_ratios, index 1 partial_gains
//
// After reset the sine table RAM is loaded by a sweep over its 1024 entries; no word is taken then.
// One word holds the block from its accepting cycle on: three steps per partial
// through the shared multiplier and its table read, one to start the divider, fifteen
// divider steps, one for its done flag and one to load the output register.
// Reset is synchronous; the phase accumulator returns to zero.
// A result waiting on rsp_tready holds the next result in the sequencer, which takes no word.
`include "additive_harmonic_oscillator_unit_macros.svh"

module additive_harmonic_oscillator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input words.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,   // [31:0] phase_step
   // Result words.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,   // [15:0] sample
   // Register writes.
   input  logic                                 csr_we,
   input  logic [ahos_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ahos_pkg::GAINS_BITS-1:0]      csr_wdata
);

   localparam int A_BITS = ahos_pkg::SINE_ADDR_BITS;

   localparam logic [2:0] ST_FILL   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PHASE  = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_WEIGHT = 3'd4;
   localparam logic [2:0] ST_START  = 3'd5;
   localparam logic [2:0] ST_DIVIDE = 3'd6;
   localparam logic [2:0] ST_HOLD   = 3'd7;

   logic [2:0]                              state_ff, state_in;
   logic [A_BITS-1:0]                       fill_ff, fill_in;
   logic [ahos_pkg::PART_BITS-1:0]          part_ff, part_in;
   logic [ahos_pkg::GSUM_BITS-1:0]          gsum_ff, gsum_in;
   logic [ahos_pkg::PHASE_BITS-1:0]         phase_ff, phase_in;
   logic [ahos_pkg::PHASE_BITS-1:0]         step_ff, step_in;
   logic [ahos_pkg::RATIOS_BITS-1:0]        ratios_ff, ratios_in;
   logic [ahos_pkg::GAINS_BITS-1:0]         gains_ff, gains_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [ahos_pkg::SAMPLE_BITS-1:0]        rsp_data_ff, rsp_data_in;

   logic                                    req_take;
   logic [ahos_pkg::PART_BITS+2:0]          part_ext;
   logic [2:0]                              field_sel;
   logic                                    field_ok;
   logic [ahos_pkg::RATIO_FIELD_BITS-1:0]   ratio_code;
   logic [ahos_pkg::GAIN_BITS-1:0]          gain;
   ahos_pkg::mac_req_type                   mac_req;
   logic [ahos_pkg::PHASE_BITS-1:0]         local_phase;
   logic signed [ahos_pkg::ACC_BITS-1:0]    acc;
   logic [1:0]                              quadrant;
   logic [A_BITS-1:0]                       table_idx;
   logic [ahos_pkg::ENTRY_BITS-1:0]         entry;
   logic signed [ahos_pkg::VALUE_BITS-1:0]  value;
   logic [ahos_pkg::ACC_BITS-1:0]           acc_abs;
   logic [ahos_pkg::GSUM_BITS-1:0]          divisor;
   logic                                    div_start;
   logic                                    div_done;
   logic signed [ahos_pkg::SAMPLE_BITS-1:0] div_quot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // Register fields of the current partial; partials past the fields are silent.
   assign part_ext   = {3'b000, part_ff};
   assign field_sel  = part_ext[2:0];
   assign field_ok   = part_ext < (ahos_pkg::PART_BITS + 3)'(ahos_pkg::REG_FIELDS);
   assign ratio_code = field_ok ?
                       ratios_ff[field_sel * ahos_pkg::RATIO_FIELD_BITS +: ahos_pkg::RATIO_FIELD_BITS]
                       : '0;
   assign gain       = field_ok ?
                       gains_ff[field_sel * ahos_pkg::GAIN_BITS +: ahos_pkg::GAIN_BITS] : '0;

   // Quadrant folding of the quarter-wave table.
   assign quadrant  = local_phase[ahos_pkg::PHASE_BITS-1 -: 2];
   assign table_idx = local_phase[ahos_pkg::PHASE_BITS-3 -: A_BITS] ^ {A_BITS{quadrant[0]}};
   assign value     = quadrant[1] ? -$signed({1'b0, entry}) : $signed({1'b0, entry});

   // Request to the shared multiplier.
   always_comb begin
      mac_req.op    = ahos_pkg::MAC_NOP;
      mac_req.phase = phase_ff;
      mac_req.ratio = {1'b0, ratio_code} + 1'b1;
      mac_req.value = value;
      mac_req.gain  = gain;
      unique case (state_ff)
         ST_IDLE:   mac_req.op = req_take ? ahos_pkg::MAC_CLEAR : ahos_pkg::MAC_NOP;
         ST_PHASE:  mac_req.op = ahos_pkg::MAC_PHASE;
         ST_WEIGHT: mac_req.op = ahos_pkg::MAC_WEIGHT;
         default:   mac_req.op = ahos_pkg::MAC_NOP;
      endcase
   end

   ahos_mac u_mac (
      .clock       (clock),
      .req         (mac_req),
      .local_phase (local_phase),
      .acc         (acc)
   );

   ahos_ram #(
      .WIDTH (ahos_pkg::ENTRY_BITS),
      .DEPTH (ahos_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (state_ff == ST_FILL),
      .waddr (fill_ff),
      .wdata (ahos_pkg::SINE_TABLE[fill_ff]),
      .raddr (table_idx),
      .rdata (entry)
   );

   // Magnitude and divisor for the normalizing division.
   assign acc_abs   = acc[ahos_pkg::ACC_BITS-1] ? ahos_pkg::ACC_BITS'(-acc)
                                                : ahos_pkg::ACC_BITS'(acc);
   assign divisor   = (gsum_ff > ahos_pkg::GSUM_BITS'(ahos_pkg::DIV_FLOOR)) ?
                      gsum_ff : ahos_pkg::GSUM_BITS'(ahos_pkg::DIV_FLOOR);
   assign div_start = (state_ff == ST_START);

   ahos_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .negative  (acc[ahos_pkg::ACC_BITS-1]),
      .magnitude (acc_abs[ahos_pkg::MAG_BITS-1:0]),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quot)
   );

   // Register writes.
   always_comb begin
      ratios_in = ratios_ff;
      gains_in  = gains_ff;
      if (csr_we) begin
         unique case (csr_index)
            ahos_pkg::CSR_RATIOS: ratios_in = csr_wdata[ahos_pkg::RATIOS_BITS-1:0];
            ahos_pkg::CSR_GAINS:  gains_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer over the partials, the division and the output hand-off.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      part_in      = part_ff;
      gsum_in      = gsum_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_FILL: begin
            fill_in = fill_ff + 1'b1;
            if (fill_ff == {A_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               step_in  = req_tdata;
               part_in  = '0;
               gsum_in  = '0;
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            gsum_in = gsum_ff + ahos_pkg::GSUM_BITS'(gain);
            part_in = part_ff + 1'b1;
            if (part_ff == ahos_pkg::PART_BITS'(ahos_pkg::NUM_PARTIALS - 1)) begin
               state_in = ST_START;
            end else begin
               state_in = ST_PHASE;
            end
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = div_quot;
               phase_in     = phase_ff + step_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         part_ff      <= '0;
         phase_ff     <= '0;
         ratios_ff    <= 32'h7654_3210;
         gains_ff     <= ahos_pkg::GAINS_BITS'(255);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         part_ff      <= part_in;
         phase_ff     <= phase_in;
         ratios_ff    <= ratios_in;
         gains_ff     <= gains_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gsum_ff     <= gsum_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted word starts at the first partial.
   `AHOS_ASSERT_NEXT(a_accept_starts, req_take, state_ff == ST_PHASE && part_ff == '0, "bad start")
   // The divider reports only while the sequencer waits for it.
   `AHOS_ASSERT_NOW(a_done_in_divide, div_done, state_ff == ST_DIVIDE, "stray divider done")
   // The phase moves only when a result is handed to the output register.
   `AHOS_ASSERT_NEXT(a_phase_steady, state_ff != ST_HOLD, $stable(phase_ff), "phase moved early")

endmodule
